[hdl/fpd_pkg.sv]
// ----------------------------------------------------------------------------
// fpd_pkg
// Shared types, constants and the CRC-16/CCITT-FALSE byte step for the
// framed packet decoder.
// ----------------------------------------------------------------------------
package fpd_pkg;

  localparam int unsigned MAX_PAYLOAD = 256;
  localparam int unsigned HDR_BYTES   = 8;
  localparam int unsigned CRC_BYTES   = 2;
  localparam int unsigned MIN_FRAME   = HDR_BYTES + CRC_BYTES;

  localparam int unsigned LEN_W = 16;
  // wide enough for header size plus any declared length
  localparam int unsigned EXT_W = LEN_W + 1;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_MAGIC   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_VERSION = 1'd1;
  localparam logic [15:0] FRAME_VERSION_RST = 16'h0001;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TOO_SHORT = 3'd1;
  localparam logic [2:0] ST_MAGIC     = 3'd2;
  localparam logic [2:0] ST_VERSION   = 3'd3;
  localparam logic [2:0] ST_LENGTH    = 3'd4;
  localparam logic [2:0] ST_SIZE      = 3'd5;
  localparam logic [2:0] ST_CRC       = 3'd6;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_REPORT  = 1'b1;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_frame;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [2:0]  status_code;
    logic [7:0]  out_version;
    logic [7:0]  out_msg_id;
    logic [15:0] out_seq;
    logic [15:0] out_length;
  } out_item_t;

  // one beat held in the input stage
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

[hdl/fpd_in_stage.sv]
// ----------------------------------------------------------------------------
// fpd_in_stage
// Input register: holds one received beat until the decode core takes it.
// ----------------------------------------------------------------------------
module fpd_in_stage import fpd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  input  logic     advance_i,
  output stage_t   stage_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.item  = item_q;

endmodule

[hdl/fpd_frame_core.sv]
// ----------------------------------------------------------------------------
// fpd_frame_core
// Per-frame state, header capture, CRC update and end-of-frame checks.
// Produces at most one result per consumed beat.
// ----------------------------------------------------------------------------
module fpd_frame_core import fpd_pkg::*; #(
  parameter int unsigned MaxPayload = MAX_PAYLOAD
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  input  stage_t               stage_i,
  input  logic                 advance_i,
  output logic                 res_valid_o,
  output out_item_t            res_o
);

  localparam int unsigned CountCap = MaxPayload + MIN_FRAME + 1;
  localparam int unsigned CntW     = $clog2(CountCap + 1);

  logic [15:0]     magic_cfg_q;
  logic [7:0]      ver_cfg_q;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      mhi_q, mhi_d;
  logic            mok_q, mok_d;
  logic [7:0]      ver_q, ver_d;
  logic [7:0]      mid_q, mid_d;
  logic [15:0]     seq_q, seq_d;
  logic [15:0]     len_q, len_d;
  logic [15:0]     rxcrc_q, rxcrc_d;

  logic [7:0]      b;
  logic            last;
  logic [EXT_W-1:0] idx_ext, pay_end, total_ext, frame_need;
  logic            in_payload, forward, crc_upd;
  logic [2:0]      status;

  assign b          = stage_i.item.rx_byte;
  assign last       = stage_i.item.end_of_frame;
  assign idx_ext    = EXT_W'(cnt_q);
  assign pay_end    = EXT_W'(HDR_BYTES) + {1'b0, len_q};
  assign in_payload = (cnt_q >= CntW'(HDR_BYTES)) && (idx_ext < pay_end);
  assign forward    = in_payload && ({1'b0, len_q} <= EXT_W'(MaxPayload));
  assign crc_upd    = (cnt_q >= CntW'(2)) && ((cnt_q < CntW'(HDR_BYTES)) || in_payload);

  always_comb begin
    mhi_d = mhi_q;
    mok_d = mok_q;
    ver_d = ver_q;
    mid_d = mid_q;
    seq_d = seq_q;
    len_d = len_q;
    case (cnt_q)
      CntW'(0): mhi_d = b;
      CntW'(1): mok_d = ({mhi_q, b} == magic_cfg_q);
      CntW'(2): ver_d = b;
      CntW'(3): mid_d = b;
      CntW'(4): seq_d = {b, 8'h00};
      CntW'(5): seq_d = {seq_q[15:8], b};
      CntW'(6): len_d = {b, 8'h00};
      CntW'(7): len_d = {len_q[15:8], b};
      default: ;
    endcase
  end

  assign crc_d   = crc_upd ? crc16_step(crc_q, b) : crc_q;
  assign rxcrc_d = {rxcrc_q[7:0], b};
  // count saturates one past the largest legal frame
  assign cnt_d   = (cnt_q < CntW'(CountCap)) ? cnt_q + CntW'(1) : CntW'(CountCap);

  assign total_ext  = EXT_W'(cnt_d);
  assign frame_need = EXT_W'(MIN_FRAME) + {1'b0, len_d};

  always_comb begin
    if (cnt_d < CntW'(MIN_FRAME)) begin
      status = ST_TOO_SHORT;
    end else if (!mok_d) begin
      status = ST_MAGIC;
    end else if (ver_d != ver_cfg_q) begin
      status = ST_VERSION;
    end else if ({1'b0, len_d} > EXT_W'(MaxPayload)) begin
      status = ST_LENGTH;
    end else if (total_ext != frame_need) begin
      status = ST_SIZE;
    end else if (crc_d != rxcrc_d) begin
      status = ST_CRC;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    res_o = '0;
    if (last) begin
      res_o.result_kind = KIND_REPORT;
      res_o.status_code = status;
      res_o.out_version = ver_d;
      res_o.out_msg_id  = mid_d;
      res_o.out_seq     = seq_d;
      res_o.out_length  = len_d;
    end else begin
      res_o.result_kind  = KIND_PAYLOAD;
      res_o.payload_byte = b;
    end
  end

  assign res_valid_o = stage_i.valid && (last || forward);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_cfg_q <= '0;
      ver_cfg_q   <= FRAME_VERSION_RST[7:0];
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_FRAME_MAGIC:   magic_cfg_q <= cfg_data_i;
        REG_FRAME_VERSION: ver_cfg_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      crc_q   <= CRC_INIT;
      mhi_q   <= '0;
      mok_q   <= 1'b0;
      ver_q   <= '0;
      mid_q   <= '0;
      seq_q   <= '0;
      len_q   <= '0;
      rxcrc_q <= '0;
    end else if (advance_i) begin
      if (last) begin
        // report sent, start the next frame clean
        cnt_q   <= '0;
        crc_q   <= CRC_INIT;
        mhi_q   <= '0;
        mok_q   <= 1'b0;
        ver_q   <= '0;
        mid_q   <= '0;
        seq_q   <= '0;
        len_q   <= '0;
        rxcrc_q <= '0;
      end else begin
        cnt_q   <= cnt_d;
        crc_q   <= crc_d;
        mhi_q   <= mhi_d;
        mok_q   <= mok_d;
        ver_q   <= ver_d;
        mid_q   <= mid_d;
        seq_q   <= seq_d;
        len_q   <= len_d;
        rxcrc_q <= rxcrc_d;
      end
    end
  end

  a_cnt_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(CountCap))
    else $error("byte count beyond cap");

  a_eof_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && last |=> cnt_q == '0 && crc_q == CRC_INIT)
    else $error("frame state not cleared after report");

  a_eof_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_i.valid && last |-> res_valid_o && res_o.result_kind == KIND_REPORT)
    else $error("last beat without report");

  a_adv_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i |-> stage_i.valid)
    else $error("advance without a held beat");

endmodule

[hdl/framed_packet_decoder_crc16_unit.sv]
// ----------------------------------------------------------------------------
// framed_packet_decoder_crc16_unit
// Streaming decoder for a framed packet with a CRC-16/CCITT-FALSE check.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid_i/in_stall_o   in_item_i  (in_item_t)
//   out      source     out_valid_o/out_stall_i out_item_o (out_item_t)
//   cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One beat per cycle sustained while out_stall_i is low; a beat is taken into
// the input register when accepted, and its result is then registered in the
// output register; the byte CRC update and end-of-frame checks sit between them.
// Output stall backs up through the input register to in_stall_o.
// Reset leaves the decoder ready for a new frame; cfg is always ready.
// ----------------------------------------------------------------------------
module framed_packet_decoder_crc16_unit import fpd_pkg::*; #(
  parameter int unsigned MaxPayload = MAX_PAYLOAD
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

  stage_t    stage;
  logic      advance, out_free, res_valid;
  out_item_t res;
  logic      out_valid_q;
  out_item_t out_item_q;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign advance     = stage.valid && out_free;

  fpd_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .advance_i  (advance),
    .stage_o    (stage)
  );

  fpd_frame_core #(
    .MaxPayload (MaxPayload)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .stage_i     (stage),
    .advance_i   (advance),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[sim/tb_framed_packet_decoder_crc16_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_framed_packet_decoder_crc16_unit
// Self-checking bench for the framed packet decoder. Frames are built byte by
// byte with a bench-side CRC, then sent with bursty valid while the result
// side stalls on changing patterns. Every accepted byte is run through a
// bench-side decoder, and each result beat is checked against the oldest
// predicted one.
// ----------------------------------------------------------------------------
module tb_framed_packet_decoder_crc16_unit;
  import fpd_pkg::*;

  localparam int unsigned COUNT_CAP = MAX_PAYLOAD + MIN_FRAME + 1;

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 tx_valid = 1'b0;
  logic                 in_stall;
  in_item_t             tx_item = '0;
  logic                 out_valid;
  logic                 rx_stall = 1'b0;
  out_item_t            out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_MAGIC;
  logic [15:0]          cfg_data = '0;

  framed_packet_decoder_crc16_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (tx_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (tx_item),
    .out_valid_o (out_valid),
    .out_stall_i (rx_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // bench-side decoder state and registers
  // --------------------------------------------------------------------------
  logic [15:0] cfg_magic   = 16'h0000;
  logic [7:0]  cfg_version = FRAME_VERSION_RST[7:0];

  int          byte_cnt  = 0;
  logic [15:0] crc_run   = CRC_INIT;
  logic [7:0]  magic_hi  = '0;
  logic        magic_hit = 1'b0;
  logic [7:0]  hld_ver   = '0;
  logic [7:0]  hld_id    = '0;
  logic [15:0] hld_seq   = '0;
  logic [15:0] hld_len   = '0;
  logic [15:0] crc_tail  = '0;

  in_item_t  tx_bytes_q[$];
  out_item_t decoded_q[$];
  int        queued_cnt = 0;
  int        taken_cnt = 0;
  int        mismatch_cnt = 0;
  logic      byte_taken = 1'b0;
  logic      long_hold_go = 1'b0;

  function automatic logic [15:0] crc_ccitt_byte(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    r = c ^ {d, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

  // returns 1 when the byte yields a result beat
  function automatic bit decode_byte(input in_item_t it, output out_item_t res);
    int         idx;
    int         pay_end;
    bit         in_pay;
    bit         fwd;
    int         total;
    logic [2:0] st;
    idx     = byte_cnt;
    pay_end = HDR_BYTES + hld_len;
    in_pay  = (idx >= HDR_BYTES) && (idx < pay_end);
    res     = '0;
    case (idx)
      0: magic_hi = it.rx_byte;
      1: magic_hit = ({magic_hi, it.rx_byte} == cfg_magic);
      2: hld_ver = it.rx_byte;
      3: hld_id = it.rx_byte;
      4: hld_seq = {it.rx_byte, 8'h00};
      5: hld_seq[7:0] = it.rx_byte;
      6: hld_len = {it.rx_byte, 8'h00};
      7: hld_len[7:0] = it.rx_byte;
      default: ;
    endcase
    if (idx >= 2 && (idx < HDR_BYTES || in_pay)) crc_run = crc_ccitt_byte(crc_run, it.rx_byte);
    crc_tail = {crc_tail[7:0], it.rx_byte};
    fwd      = in_pay && (hld_len <= MAX_PAYLOAD);
    total    = (idx < COUNT_CAP) ? idx + 1 : COUNT_CAP;
    byte_cnt = total;

    if (!it.end_of_frame) begin
      if (fwd) begin
        res.result_kind  = KIND_PAYLOAD;
        res.payload_byte = it.rx_byte;
        return 1'b1;
      end
      return 1'b0;
    end

    if (total < MIN_FRAME)                st = ST_TOO_SHORT;
    else if (!magic_hit)                  st = ST_MAGIC;
    else if (hld_ver != cfg_version)      st = ST_VERSION;
    else if (hld_len > MAX_PAYLOAD)       st = ST_LENGTH;
    else if (total != MIN_FRAME + hld_len) st = ST_SIZE;
    else if (crc_run != crc_tail)         st = ST_CRC;
    else                                  st = ST_OK;

    res.result_kind = KIND_REPORT;
    res.status_code = st;
    res.out_version = hld_ver;
    res.out_msg_id  = hld_id;
    res.out_seq     = hld_seq;
    res.out_length  = hld_len;

    // every frame starts clean; registers persist
    byte_cnt  = 0;
    crc_run   = CRC_INIT;
    magic_hi  = '0;
    magic_hit = 1'b0;
    hld_ver   = '0;
    hld_id    = '0;
    hld_seq   = '0;
    hld_len   = '0;
    crc_tail  = '0;
    return 1'b1;
  endfunction

  task automatic flag_error(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // sender: bursts of beats with random gaps
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    if (rst_n && (!tx_valid || byte_taken)) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        tx_valid <= 1'b0;
      end else if (tx_bytes_q.size() != 0) begin
        tx_valid <= 1'b1;
        tx_item  <= tx_bytes_q.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 60);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        tx_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: stall pattern changes every so often, plus one long hold-off
  // --------------------------------------------------------------------------
  rx_mode_e rx_mode = RX_FREE;
  int       mode_left = 0;
  int       hold_left = 0;
  int       stall_tick = 0;
  logic     long_hold_seen = 1'b0;

  always @(negedge clk) begin
    stall_tick <= stall_tick + 1;
    if (hold_left != 0) begin
      rx_stall  <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (long_hold_go && !long_hold_seen) begin
      long_hold_seen <= 1'b1;
      hold_left      <= 400;
      rx_stall       <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= rx_mode_e'($urandom_range(0, 3));
        mode_left <= $urandom_range(10, 150);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        RX_FREE:  rx_stall <= 1'b0;
        RX_LIGHT: rx_stall <= ($urandom_range(0, 9) < 3);
        RX_HEAVY: rx_stall <= ($urandom_range(0, 9) < 7);
        default:  rx_stall <= (stall_tick % 3 == 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // monitor: check result beats, predict from accepted byte beats
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : mon
    out_item_t want;
    out_item_t pred;
    if (rst_n) begin
      if (out_valid && !rx_stall) begin
        if (decoded_q.size() == 0) begin
          flag_error($sformatf("result beat with nothing expected: %p", out_item));
        end else begin
          want = decoded_q.pop_front();
          if (out_item.result_kind  !== want.result_kind  ||
              out_item.payload_byte !== want.payload_byte ||
              out_item.status_code  !== want.status_code  ||
              out_item.out_version  !== want.out_version  ||
              out_item.out_msg_id   !== want.out_msg_id   ||
              out_item.out_seq      !== want.out_seq      ||
              out_item.out_length   !== want.out_length)
            flag_error({$sformatf(
              "exp kind=%0d byte=%02h st=%0d ver=%02h id=%02h seq=%04h len=%04h",
              want.result_kind, want.payload_byte, want.status_code, want.out_version,
              want.out_msg_id, want.out_seq, want.out_length),
              $sformatf(
              " / got kind=%0d byte=%02h st=%0d ver=%02h id=%02h seq=%04h len=%04h",
              out_item.result_kind, out_item.payload_byte, out_item.status_code,
              out_item.out_version, out_item.out_msg_id, out_item.out_seq,
              out_item.out_length)});
        end
      end
      byte_taken <= tx_valid && !in_stall;
      if (tx_valid && !in_stall) begin
        taken_cnt++;
        if (decode_byte(tx_item, pred)) decoded_q.push_back(pred);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  task automatic queue_byte(input logic [7:0] b, input logic eof);
    in_item_t it;
    it.rx_byte      = b;
    it.end_of_frame = eof;
    tx_bytes_q.push_back(it);
    queued_cnt++;
  endtask

  // cut > 0 sends only the first cut bytes; extra appends junk after the CRC
  task automatic queue_frame(input logic [15:0] magic, input logic [7:0] ver,
                             input int len_decl, input int pay_n, input bit crc_bad,
                             input int cut, input int extra);
    logic [7:0]  fb[$];
    logic [7:0]  b;
    logic [15:0] c;
    logic [15:0] ld;
    int          n;
    ld = 16'(len_decl);
    fb.push_back(magic[15:8]);
    fb.push_back(magic[7:0]);
    fb.push_back(ver);
    for (int i = 0; i < 3; i++) begin
      b = 8'($urandom_range(0, 255));
      fb.push_back(b);
    end
    fb.push_back(ld[15:8]);
    fb.push_back(ld[7:0]);
    c = CRC_INIT;
    for (int i = 2; i < HDR_BYTES; i++) c = crc_ccitt_byte(c, fb[i]);
    for (int i = 0; i < pay_n; i++) begin
      b = 8'($urandom_range(0, 255));
      fb.push_back(b);
      c = crc_ccitt_byte(c, b);
    end
    if (crc_bad) c = c ^ 16'($urandom_range(1, 65535));
    fb.push_back(c[15:8]);
    fb.push_back(c[7:0]);
    for (int i = 0; i < extra; i++) begin
      b = 8'($urandom_range(0, 255));
      fb.push_back(b);
    end
    n = (cut > 0 && cut < fb.size()) ? cut : fb.size();
    for (int i = 0; i < n; i++) queue_byte(fb[i], i == n - 1);
  endtask

  task automatic queue_random_frame();
    int          pay_n;
    int          len_decl;
    int          cut;
    int          extra;
    int          n;
    int          flip;
    logic [15:0] mg;
    logic [7:0]  vr;
    logic [7:0]  b;
    if ($urandom_range(0, 99) < 8) begin
      // line noise, may or may not close a frame
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
        b = 8'($urandom_range(0, 255));
        queue_byte(b, $urandom_range(0, 7) == 0);
      end
      return;
    end
    pay_n    = ($urandom_range(0, 19) == 0) ? $urandom_range(0, MAX_PAYLOAD)
                                            : $urandom_range(0, 12);
    len_decl = pay_n;
    if ($urandom_range(0, 99) < 12) begin
      case ($urandom_range(0, 3))
        0:       len_decl = pay_n + 1;
        1:       len_decl = (pay_n > 0) ? pay_n - 1 : 1;
        2:       len_decl = $urandom_range(0, 65535);
        default: len_decl = MAX_PAYLOAD + $urandom_range(1, 4);
      endcase
    end
    mg = cfg_magic;
    if ($urandom_range(0, 99) < 10) begin
      if ($urandom_range(0, 1) == 0) begin
        mg = 16'($urandom_range(0, 65535));
      end else begin
        flip     = $urandom_range(0, 15);
        mg[flip] = ~mg[flip];
      end
    end
    vr = cfg_version;
    if ($urandom_range(0, 99) < 10) vr = 8'($urandom_range(0, 255));
    cut   = ($urandom_range(0, 99) < 7) ? $urandom_range(1, MIN_FRAME + pay_n) : 0;
    extra = ($urandom_range(0, 99) < 5) ? $urandom_range(1, 4) : 0;
    queue_frame(mg, vr, len_decl, pay_n, $urandom_range(0, 99) < 12, cut, extra);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_FRAME_MAGIC) cfg_magic = val;
    else cfg_version = val[7:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait for every byte to be taken and every result to drain, then a tail
  task automatic settle();
    do @(negedge clk); while (taken_cnt != queued_cnt || decoded_q.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    int          phase_start;
    logic [15:0] d;
    wait (rst_n);
    @(negedge clk);

    // reset register values
    queue_frame(16'h0000, 8'h01, 0, 0, 1'b0, 0, 0);
    queue_frame(16'h0000, 8'h01, 2, 2, 1'b0, 1, 0);   // lone flagged byte
    queue_frame(16'h0000, 8'h01, 5, 5, 1'b0, 9, 0);   // one byte under minimum
    settle();

    write_reg(REG_FRAME_MAGIC, 16'hFFFF);
    write_reg(REG_FRAME_VERSION, 16'hFFFF);
    queue_frame(16'hFFFF, 8'hFF, MAX_PAYLOAD, MAX_PAYLOAD, 1'b0, 0, 0);
    queue_frame(16'hFFFE, 8'hFF, 1, 1, 1'b0, 0, 0);   // magic off by one bit
    queue_frame(16'hFFFF, 8'h00, 1, 1, 1'b0, 0, 0);   // wrong version
    queue_frame(16'hFFFF, 8'hFF, MAX_PAYLOAD + 1, 3, 1'b0, 0, 0);
    queue_frame(16'hFFFF, 8'hFF, 65535, 0, 1'b0, 0, 0);
    queue_frame(16'hFFFF, 8'hFF, 4, 6, 1'b0, 0, 0);   // payload longer than declared
    queue_frame(16'hFFFF, 8'hFF, 20, 20, 1'b0, 13, 0); // flag lands inside payload
    queue_frame(16'hFFFF, 8'hFF, 3, 3, 1'b1, 0, 0);
    // overlong frame, byte count saturates
    queue_frame(16'hFFFF, 8'hFF, MAX_PAYLOAD, MAX_PAYLOAD, 1'b0, 0, 30);
    settle();

    write_reg(REG_FRAME_MAGIC, 16'h0000);
    write_reg(REG_FRAME_VERSION, 16'hFF00);           // upper data bits ignored
    queue_frame(16'h0000, 8'h00, 7, 7, 1'b0, 0, 0);
    queue_frame(16'h0000, 8'h00, 0, 0, 1'b1, 0, 0);
    settle();

    for (int p = 0; p < 4; p++) begin
      write_reg(REG_FRAME_MAGIC, 16'($urandom_range(0, 65535)));
      d = 16'($urandom_range(0, 65535));
      write_reg(REG_FRAME_VERSION, d);
      phase_start = queued_cnt;
      while (queued_cnt - phase_start < 60) queue_random_frame();
      // close the phase on a frame boundary so the registers can change
      queue_frame(cfg_magic, cfg_version, 2, 2, 1'b0, 0, 0);
      if (p == 1) long_hold_go <= 1'b1;
      settle();
    end

    if (mismatch_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
